// ----- rtl/core/bgc_pkg.sv -----
// Shared constants, codes and types of the button gesture classifier.
`default_nettype none
package bgc_pkg;

    localparam int HISTORY_DEPTH   = 30;
    localparam int LONG_LONG_TICKS = 40;
    localparam int RELEASE_POS     = 8;
    localparam int LONG_TICKS      = 20;
    localparam int QUIET_POS       = 4;
    localparam int HOLD_MAX        = 63;

    localparam int HOLD_W  = 6;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH);
    localparam int CLICK_W = 3;
    localparam int GEST_W  = 4;

    typedef logic [1:0] status_t;

    localparam status_t ST_OPEN  = 2'd0;
    localparam status_t ST_POWER = 2'd1;
    localparam status_t ST_USER  = 2'd2;

    // Gesture codes for the power switch; the user switch adds G_USER_OFS.
    localparam logic [GEST_W-1:0] G_SINGLE    = 4'd0;
    localparam logic [GEST_W-1:0] G_LONG      = 4'd3;
    localparam logic [GEST_W-1:0] G_LONG_LONG = 4'd4;
    localparam logic [GEST_W-1:0] G_USER_OFS  = 4'd5;

    localparam logic [CLICK_W-1:0] CLICK_SAT = 3'd4;

    // Per-cell history control.
    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
    } cell_ctrl_t;

    // Click scanner status toward the controller.
    typedef struct packed {
        logic                busy;
        logic                last;
        logic [CLICK_W-1:0]  clicks;
    } scan_stat_t;

endpackage : bgc_pkg
`default_nettype wire

// ----- rtl/core/bgc_cell.sv -----
// One history cell: holds one switch status, shifts, rotates or clears.
`default_nettype none
module bgc_cell
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  bgc_pkg::cell_ctrl_t  ctrl,
    input  bgc_pkg::status_t     left,
    input  bgc_pkg::status_t     right,
    output bgc_pkg::status_t     q
);

    bgc_pkg::status_t q_reg;
    bgc_pkg::status_t q_next;

    always_comb
    begin
        priority if (ctrl.shift)
        begin
            q_next = ctrl.clear ? bgc_pkg::ST_OPEN : left;
        end
        else if (ctrl.rotate)
        begin
            q_next = right;
        end
        else if (ctrl.clear)
        begin
            q_next = bgc_pkg::ST_OPEN;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= bgc_pkg::ST_OPEN;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule : bgc_cell
`default_nettype wire

// ----- rtl/core/bgc_scan.sv -----
// Click scanner: watches the head of the rotating history and counts clicks.
`default_nettype none
module bgc_scan
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  bgc_pkg::status_t     target,
    input  bgc_pkg::status_t     head,
    input  bgc_pkg::status_t     second,
    output bgc_pkg::scan_stat_t  stat
);

    localparam logic [bgc_pkg::CNT_W-1:0] LAST_IDX =
        bgc_pkg::CNT_W'(bgc_pkg::HISTORY_DEPTH - 1);
    localparam logic [bgc_pkg::CNT_W-1:0] QUIET_LAST =
        bgc_pkg::CNT_W'(bgc_pkg::QUIET_POS - 1);
    localparam logic [bgc_pkg::CNT_W-1:0] PAIR_LAST =
        bgc_pkg::CNT_W'(bgc_pkg::HISTORY_DEPTH - 2);

    logic                           busy_reg,    busy_next;
    logic [bgc_pkg::CNT_W-1:0]      cnt_reg,     cnt_next;
    logic                           pressed_reg, pressed_next;
    logic                           quiet_reg,   quiet_next;
    logic [bgc_pkg::CLICK_W-1:0]    clicks_reg,  clicks_next;
    bgc_pkg::status_t               target_reg,  target_next;

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        pressed_next = pressed_reg;
        quiet_next   = quiet_reg;
        clicks_next  = clicks_reg;
        target_next  = target_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            pressed_next = 1'b0;
            quiet_next   = 1'b1;
            clicks_next  = '0;
            target_next  = target;
        end
        else if (busy_reg)
        begin
            // head holds entry cnt, second holds entry cnt+1
            if (cnt_reg <= QUIET_LAST && head != bgc_pkg::ST_OPEN)
            begin
                quiet_next = 1'b0;
            end
            if (cnt_reg >= QUIET_LAST && cnt_reg <= PAIR_LAST)
            begin
                if (!pressed_reg && head == bgc_pkg::ST_OPEN && second == target_reg)
                begin
                    pressed_next = 1'b1;
                end
                else if (pressed_reg && head == target_reg && second == bgc_pkg::ST_OPEN)
                begin
                    pressed_next = 1'b0;
                    if (clicks_reg != bgc_pkg::CLICK_SAT)
                    begin
                        clicks_next = clicks_reg + 1'b1;
                    end
                end
            end
            if (cnt_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        pressed_reg <= pressed_next;
        quiet_reg   <= quiet_next;
        clicks_reg  <= clicks_next;
        target_reg  <= target_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.last   = busy_reg && (cnt_reg == LAST_IDX);
    assign stat.clicks = quiet_reg ? clicks_reg : '0;

endmodule : bgc_scan
`default_nettype wire

// ----- rtl/core/button_gesture_classifier.sv -----
// Top level of the button gesture classifier: control, hold counter, cell row, ports.
//
// Usage:
// - Input stream (s_tvalid/s_tready/s_tdata): one word per 20 Hz switch sample,
//   s_tdata[0] = power_pressed, s_tdata[1] = user_pressed, upper bits zero.
// - Output stream (m_tvalid/m_tready/m_tdata): zero or one word per sample,
//   m_tdata[3:0] = gesture (0..4 power single/double/triple/long/long-long,
//   5..9 the same for the user switch).
// - APB port: register 0 at address 0 is user_switch_enable (bit 0).
// Timing:
// - A sample that does not trigger a click scan is taken in IDLE alone; one that
//   gives a long or long-long event also passes PUSH (accept, then load output).
// - A release whose press sits at history position 8 starts a click scan:
//   the 30-cell history row rotates by one cell per cycle past the scanner,
//   so that sample goes through accept, rotate, finish and load output with a click
//   result, or skips the load without one; s_tready is high only while idle.
// Reset: history all open, hold counter 41 (a press held at power-up is
//   ignored until released), switch enable 0, output empty.
// Stall: a result waits in the output register; the next sample is still
//   taken, and only a further result waits until the receiver takes it.
`default_nettype none
module button_gesture_classifier
(
    input  wire         clk,
    input  wire         rst_n,
    // input samples
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [0] power_pressed, [1] user_pressed
    // gestures
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [3:0] gesture
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HD = bgc_pkg::HISTORY_DEPTH;

    // controller states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam logic [1:0] S_PUSH   = 2'd3;

    localparam logic [2:0] ADDR_USER_EN = 3'd0;

    localparam logic [bgc_pkg::HOLD_W-1:0] HOLD_RESET =
        bgc_pkg::HOLD_W'(bgc_pkg::LONG_LONG_TICKS + 1);
    localparam logic [bgc_pkg::HOLD_W-1:0] HOLD_LONG =
        bgc_pkg::HOLD_W'(bgc_pkg::LONG_TICKS);
    localparam logic [bgc_pkg::HOLD_W-1:0] HOLD_LONG_LONG =
        bgc_pkg::HOLD_W'(bgc_pkg::LONG_LONG_TICKS);
    localparam logic [bgc_pkg::HOLD_W-1:0] HOLD_TOP =
        bgc_pkg::HOLD_W'(bgc_pkg::HOLD_MAX);

    logic [1:0]                      state_reg, state_next;
    logic [bgc_pkg::HOLD_W-1:0]      hold_reg,  hold_next;
    logic                            user_en_reg, user_en_next;
    bgc_pkg::status_t                sw_reg,    sw_next;
    logic [bgc_pkg::GEST_W-1:0]      pend_reg,  pend_next;
    logic                            mvalid_reg, mvalid_next;
    logic [bgc_pkg::GEST_W-1:0]      mdata_reg,  mdata_next;

    bgc_pkg::status_t     hist [HD];
    bgc_pkg::status_t     sw_in;
    bgc_pkg::status_t     shift_val;
    bgc_pkg::status_t     released;
    bgc_pkg::scan_stat_t  scan_stat;
    logic                 accept;
    logic                 shift_en;
    logic                 clr_en;
    logic                 scan_start;
    logic                 cfg_write;
    logic                 hold_long;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;

    // Power wins; the user switch counts only when enabled.
    always_comb
    begin
        priority if (s_tdata[0])
        begin
            sw_in = bgc_pkg::ST_POWER;
        end
        else if (user_en_reg && s_tdata[1])
        begin
            sw_in = bgc_pkg::ST_USER;
        end
        else
        begin
            sw_in = bgc_pkg::ST_OPEN;
        end
    end

    assign hold_long = (hold_reg > HOLD_LONG);
    // A release after a long press wipes the history before it is looked at.
    assign released  = hold_long ? bgc_pkg::ST_OPEN : hist[bgc_pkg::RELEASE_POS];
    assign shift_val = (state_reg == S_FINISH) ? sw_reg : sw_in;

    always_comb
    begin
        state_next  = state_reg;
        hold_next   = hold_reg;
        sw_next     = sw_reg;
        pend_next   = pend_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        shift_en    = 1'b0;
        clr_en      = 1'b0;
        scan_start  = 1'b0;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sw_next = sw_in;
                    if (sw_in == bgc_pkg::ST_OPEN)
                    begin
                        hold_next = '0;
                        clr_en    = hold_long;
                        if (released != bgc_pkg::ST_OPEN)
                        begin
                            // hold the history in place; rotate it past the scanner
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            shift_en = 1'b1;
                        end
                    end
                    else
                    begin
                        shift_en = 1'b1;
                        priority if (hold_reg == HOLD_LONG)
                        begin
                            pend_next  = (sw_in == bgc_pkg::ST_USER)
                                       ? bgc_pkg::G_LONG + bgc_pkg::G_USER_OFS
                                       : bgc_pkg::G_LONG;
                            hold_next  = hold_reg + 1'b1;
                            state_next = S_PUSH;
                        end
                        else if (hold_reg == HOLD_LONG_LONG)
                        begin
                            pend_next  = (sw_in == bgc_pkg::ST_USER)
                                       ? bgc_pkg::G_LONG_LONG + bgc_pkg::G_USER_OFS
                                       : bgc_pkg::G_LONG_LONG;
                            hold_next  = hold_reg + 1'b1;
                            state_next = S_PUSH;
                        end
                        else if (sw_in == hist[0] && hold_reg != HOLD_TOP)
                        begin
                            hold_next = hold_reg + 1'b1;
                        end
                        else
                        begin
                            hold_next = hold_reg;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_stat.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // history is back in place; drop it if any click was found
                shift_en = 1'b1;
                clr_en   = (scan_stat.clicks != '0);
                if (scan_stat.clicks != '0 && scan_stat.clicks != bgc_pkg::CLICK_SAT)
                begin
                    pend_next  = bgc_pkg::G_SINGLE
                               + bgc_pkg::GEST_W'(scan_stat.clicks - 1'b1)
                               + ((hist[bgc_pkg::RELEASE_POS] == bgc_pkg::ST_USER)
                                  ? bgc_pkg::G_USER_OFS : '0);
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = pend_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The released entry sits at position 8 when the scan starts and again
    // when the row is back in place, so FINISH reads its kind from there.

    // Cell row: entry 0 newest; rotate moves entry i+1 into cell i.
    for (genvar i = 0; i < HD; i++)
    begin : g_cell
        bgc_pkg::cell_ctrl_t ctrl;
        assign ctrl.shift  = shift_en;
        assign ctrl.rotate = scan_stat.busy;
        assign ctrl.clear  = (i == 0) ? (clr_en && !shift_en) : clr_en;

        bgc_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  ((i == 0) ? shift_val : hist[(i + HD - 1) % HD]),
            .right (hist[(i + 1) % HD]),
            .q     (hist[i])
        );
    end

    bgc_scan u_scan
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .target (released),
        .head   (hist[0]),
        .second (hist[1]),
        .stat   (scan_stat)
    );

    always_comb
    begin
        user_en_next = user_en_reg;
        if (cfg_write && paddr == ADDR_USER_EN)
        begin
            user_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hold_reg    <= HOLD_RESET;
            user_en_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hold_reg    <= hold_next;
            user_en_reg <= user_en_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg    <= sw_next;
        pend_reg  <= pend_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(8 - bgc_pkg::GEST_W){1'b0}}, mdata_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_USER_EN) ? {31'b0, user_en_reg} : 32'b0;

endmodule : button_gesture_classifier
`default_nettype wire

// ----- rtl/core/bgc_checker.sv -----
// Port-level checker for the button gesture classifier, bound to the top level.
`default_nettype none
module bgc_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [7:0]  m_tdata,
    input wire        pready
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_gesture_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9) && (m_tdata[7:4] == 4'd0))
        else $error("gesture code out of range");

    // A new word is loaded only while a sample is in work.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word appeared while idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule : bgc_checker

bind button_gesture_classifier bgc_checker u_bgc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire

// ----- tb/sv/gesture_checker.sv -----
// Checker for the button gesture classifier: tracks the switch history and compares gestures.
module gesture_checker
    import bgc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // [0] power_pressed, [1] user_pressed
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,   // [3:0] gesture
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] REG_USER_SW_EN = 3'd0;

    status_t           history [HISTORY_DEPTH];
    logic [HOLD_W-1:0] hold_ticks;
    logic              user_sw_en;
    logic [GEST_W-1:0] expected_gestures [$];
    int                n_fail = 0;

    function automatic void wipe_history();
        for (int i = 0; i < HISTORY_DEPTH; i++)
            history[i] = ST_OPEN;
    endfunction

    // Count complete presses of one switch behind a quiet head of history.
    function automatic int count_clicks(input status_t target);
        int   clicks;
        logic in_press;
        clicks   = 0;
        in_press = 1'b0;
        for (int i = 0; i < QUIET_POS; i++)
            if (history[i] != ST_OPEN)
                return 0;
        for (int i = QUIET_POS; i < HISTORY_DEPTH; i++)
        begin
            if (!in_press && history[i-1] == ST_OPEN && history[i] == target)
                in_press = 1'b1;
            else if (in_press && history[i-1] == target && history[i] == ST_OPEN)
            begin
                clicks++;
                in_press = 1'b0;
            end
        end
        return clicks;
    endfunction

    // Advance the tracked state by one switch sample; report a gesture if one fires.
    function automatic void classify_sample(input logic pwr, input logic usr,
                                            output logic hit,
                                            output logic [GEST_W-1:0] gest);
        status_t           sw;
        status_t           released;
        int                clicks;
        logic [GEST_W-1:0] ofs;
        hit  = 1'b0;
        gest = '0;
        if (pwr)
            sw = ST_POWER;
        else if (user_sw_en && usr)
            sw = ST_USER;
        else
            sw = ST_OPEN;
        ofs = (sw == ST_USER) ? G_USER_OFS : '0;

        if (sw == ST_OPEN)
        begin
            // release after a long press: forget the clicks
            if (hold_ticks > LONG_TICKS)
                wipe_history();
            hold_ticks = '0;
            released   = history[RELEASE_POS];
            if (released == ST_POWER || released == ST_USER)
            begin
                clicks = count_clicks(released);
                if (clicks > 0)
                    wipe_history();
                if (clicks >= 1 && clicks <= 3)
                begin
                    hit  = 1'b1;
                    gest = G_SINGLE + GEST_W'(clicks - 1)
                         + ((released == ST_USER) ? G_USER_OFS : '0);
                end
            end
        end
        else if (hold_ticks == LONG_TICKS)
        begin
            hit  = 1'b1;
            gest = G_LONG + ofs;
            hold_ticks++;
        end
        else if (hold_ticks == LONG_LONG_TICKS)
        begin
            hit  = 1'b1;
            gest = G_LONG_LONG + ofs;
            hold_ticks++;
        end
        else if (sw == history[0] && hold_ticks < HOLD_MAX)
        begin
            hold_ticks++;
        end

        for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = sw;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic              hit;
        logic [GEST_W-1:0] gest;
        logic [GEST_W-1:0] want;
        if (!rst_n)
        begin
            wipe_history();
            hold_ticks = HOLD_W'(LONG_LONG_TICKS + 1);
            user_sw_en = 1'b0;
            expected_gestures.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected gesture %0d, none predicted", m_tdata[3:0]);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (m_tdata[3:0] !== want)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("gesture mismatch: expected %0d, got %0d",
                                     want, m_tdata[3:0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                classify_sample(s_tdata[0], s_tdata[1], hit, gest);
                if (hit)
                    expected_gestures.push_back(gest);
            end
            if (psel && penable && pwrite && pready && paddr == REG_USER_SW_EN)
                user_sw_en = pwdata[0];
            pending <= expected_gestures.size();
        end
        fail_count <= n_fail;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the gesture classifier testbench: clock, reset, stimulus and verdict.
module tb_top;

    localparam logic [2:0] REG_USER_SW_EN   = 3'd0;
    localparam int         SETTLE_CYCLES    = 48;     // long enough for one click scan to run out
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         TIME_LIMIT       = 2000000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [0] power_pressed, [1] user_pressed
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [3:0] gesture
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending;
    int   n_sent       = 0;
    int   burst_left   = 0;
    logic sw_enabled   = 1'b0;   // what the enable register was last set to
    logic long_hold_go = 1'b0;   // ask the receiver for one long hold-off

    always #1 clk = ~clk;

    button_gesture_classifier dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gesture_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one sample word and hold it until the block takes it. Ready is sampled
    // at the falling edge, where it is stable, so the word moves at the next rising
    // edge. Bursts of random length may end in a random gap with valid low.
    task automatic send_sample(input logic pwr, input logic usr);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, usr, pwr};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        n_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // half the bursts run straight into the next one
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold one switch down for len ticks; the user bit is noise under a power press.
    task automatic press_run(input logic is_user, input int len);
        repeat (len)
        begin
            if (is_user)
                send_sample(1'b0, 1'b1);
            else
                send_sample(1'b1, 1'($urandom_range(0, 1)));
        end
    endtask

    // Both switches open; a disabled user switch may chatter freely.
    task automatic release_run(input int len);
        repeat (len)
            send_sample(1'b0, sw_enabled ? 1'b0 : 1'($urandom_range(0, 1)));
    endtask

    // One random gesture attempt: clicks, a long hold, a switch swap while held,
    // or raw noise.
    task automatic play_gesture();
        int   kind;
        int   n_clicks;
        logic is_user;
        kind    = $urandom_range(0, 9);
        is_user = sw_enabled ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) == 0);
        if (kind <= 4)
        begin
            // one to four clicks; short gaps keep the scan from firing early
            n_clicks = $urandom_range(1, 4);
            for (int i = 0; i < n_clicks; i++)
            begin
                press_run(is_user, $urandom_range(1, 6));
                if (i < n_clicks - 1)
                    release_run($urandom_range(1, 3));
            end
            release_run($urandom_range(8, 14));
        end
        else if (kind <= 6)
        begin
            // long, long-long and hold saturation
            press_run(is_user, $urandom_range(18, 70));
            release_run($urandom_range(4, 12));
        end
        else if (kind == 7)
        begin
            press_run(is_user, $urandom_range(2, 25));
            press_run(!is_user, $urandom_range(2, 25));
            release_run($urandom_range(8, 14));
        end
        else
        begin
            repeat ($urandom_range(4, 20))
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic play_until(input int total);
        while (n_sent < total)
            play_gesture();
    endtask

    // Stop offering words, wait for every predicted gesture, then let any scan
    // that produces nothing run out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the word at the edge
    // that ends the access with pready high.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: ready follows a pattern of its own, changing mode after a span of random
    // length, and on request holds off for one long stretch so the block backs up.
    initial
    begin : receiver
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_go)
            begin
                long_hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_write(REG_USER_SW_EN, 32'd0);
        sw_enabled = 1'b0;

        // Directed: a press held since power-on is dropped on release, then a
        // plain power click, a user press while the user switch is disabled,
        // and both switches at once (power wins).
        press_run(1'b0, 3);
        send_sample(1'b0, 1'b0);
        press_run(1'b0, 2);
        release_run(10);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        release_run(9);
        drain();

        reg_write(REG_USER_SW_EN, 32'd1);
        sw_enabled = 1'b1;
        play_until(450);

        // back up the output while the sender keeps going
        long_hold_go = 1'b1;
        play_until(650);
        drain();
        play_until(750);
        drain();

        reg_write(REG_USER_SW_EN, 32'd0);
        sw_enabled = 1'b0;
        play_until(1000);
        drain();

        reg_write(REG_USER_SW_EN, 32'd1);
        sw_enabled = 1'b1;
        play_until(1270);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #TIME_LIMIT;
        $display("FAILURE");
        $finish;
    end

endmodule
